>>> hw/rtl/sc2a_pkg.sv
// shared constants, types and translation tables for the scancode to ascii fifo
package sc2a_pkg;

    // default ring depth; the ring holds one entry fewer than this
    localparam int unsigned BUFFER_DEPTH_DEF = 128;

    // word kinds on the input channel
    typedef enum logic [1:0] {
        KIND_SCAN  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    // special scancodes (set 1)
    localparam logic [7:0] CODE_EXT_PREFIX = 8'hE0;
    localparam logic [6:0] CODE_LSHIFT     = 7'h2A;
    localparam logic [6:0] CODE_RSHIFT     = 7'h36;
    localparam logic [6:0] CODE_ALT        = 7'h38;
    localparam logic [6:0] CODE_CTRL       = 7'h1D;

    // number of codes covered by the lookup tables
    localparam int unsigned TABLE_LEN = 92;

    localparam logic [7:0] PLAIN_ROM [0:TABLE_LEN-1] = '{
        8'h00,
        8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
        8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74,
        8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61,
        8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B, 8'h27,
        8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D,
        8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h3B, 8'h3C,
        8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h00, 8'h00,
        8'h47, 8'h72, 8'h49, 8'h2D, 8'h4B, 8'h00, 8'h77, 8'h2B, 8'h4F, 8'h80,
        8'h51, 8'h52, 8'h53, 8'h00, 8'h00, 8'h5C, 8'h85, 8'h86, 8'h00, 8'h00,
        8'h00
    };

    localparam logic [7:0] SHIFT_ROM [0:TABLE_LEN-1] = '{
        8'h00,
        8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28,
        8'h29, 8'h5F, 8'h2B, 8'h08, 8'h15, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54,
        8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'h00, 8'h41,
        8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A, 8'h22,
        8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D,
        8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h54, 8'h55,
        8'h56, 8'h57, 8'h58, 8'h59, 8'h5A, 8'h5B, 8'h5C, 8'h5D, 8'h00, 8'h00,
        8'h47, 8'h72, 8'h49, 8'h2D, 8'h4B, 8'h00, 8'h77, 8'h2B, 8'h4F, 8'h80,
        8'h51, 8'h52, 8'h53, 8'h00, 8'h00, 8'h5C, 8'h87, 8'h88, 8'h00, 8'h00,
        8'h00
    };

    // result word layout in m_tdata
    localparam int unsigned OUT_DATA_W = 16;

endpackage

>>> hw/rtl/scancode_to_ascii_fifo_top.sv
// scancode (set 1) to ascii translator with a character ring buffer
//
//   channel  dir  tdata (low bit up)                             tuser
//   s_       in   data_byte[7:0]                                 kind[1:0]
//   m_       out  char_out[7:0] pushed dropped shift ctrl alt 0  char_valid
//
// one word in, one word out; a new word is taken every cycle when the
// output side keeps up. between input accept and m_tvalid lie the middle
// stage for the ring read (registered ram port) and the output register.
// aresetn (synchronous) clears modifier flags, ring pointers and valid bits;
// the ring contents are not cleared and need no clearing pass.
// a stall on m_tready holds the output word and backs up into s_tready.
module scancode_to_ascii_fifo_top
    import sc2a_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // data_byte[7:0]
    input  logic [1:0]            s_tuser,   // kind[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // char_out[7:0], pushed[8], dropped[9], shift_held[10], ctrl_held[11],
    // alt_held[12], zero[15:13]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser    // char_valid
);

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(BUFFER_DEPTH - 1);

    // control state
    logic          ext_reg, ext_next;
    logic          shift_reg, shift_next;
    logic          ctrl_reg, ctrl_next;
    logic          alt_reg, alt_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [AW-1:0] wr_idx_reg, wr_idx_next;

    // middle stage (ring read in flight)
    logic          st1_valid_reg;
    logic          st1_pop_reg;
    logic          st1_pushed_reg;
    logic          st1_dropped_reg;
    logic [2:0]    st1_mods_reg;

    // output register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_user_reg;

    logic          s_accept;
    logic          out_free;
    logic          st1_free;
    kind_t         kind_in;
    logic [7:0]    byte_in;
    logic [6:0]    code7;
    logic          released;
    logic [AW-1:0] wr_inc;
    logic [AW-1:0] rd_inc;
    logic          ring_full;
    logic          ring_empty;
    logic          push_req;
    logic [7:0]    push_data;
    logic          push_ok;
    logic          push_lost;
    logic          pop;
    logic [7:0]    rom_char;
    logic [7:0]    ram_rd_data;

    // handshake and flow control
    assign out_free = !out_valid_reg || m_tready;
    assign st1_free = !st1_valid_reg || out_free;
    assign s_tready = st1_free;
    assign s_accept = s_tvalid && s_tready;

    assign kind_in  = kind_t'(s_tuser);
    assign byte_in  = s_tdata;
    assign code7    = byte_in[6:0];
    assign released = byte_in[7];

    // ring pointer arithmetic
    assign wr_inc     = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + 1'b1;
    assign rd_inc     = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + 1'b1;
    assign ring_full  = (wr_inc == rd_idx_reg);
    assign ring_empty = (wr_idx_reg == rd_idx_reg);

    // table lookup for plain make codes
    always_comb begin
        if (32'(code7) < TABLE_LEN) begin
            rom_char = shift_reg ? SHIFT_ROM[code7] : PLAIN_ROM[code7];
        end else begin
            rom_char = 8'h00;
        end
    end

    // decode of the incoming word
    always_comb begin
        ext_next   = ext_reg;
        shift_next = shift_reg;
        ctrl_next  = ctrl_reg;
        alt_next   = alt_reg;
        push_req   = 1'b0;
        push_data  = byte_in;
        pop        = 1'b0;
        unique case (kind_in)
            KIND_SCAN: begin
                if (byte_in == CODE_EXT_PREFIX) begin
                    ext_next = 1'b1;
                end else begin
                    ext_next = 1'b0;
                    // extended codes never match modifiers or the tables
                    if (!ext_reg) begin
                        priority if (code7 == CODE_LSHIFT || code7 == CODE_RSHIFT) begin
                            shift_next = !released;
                        end else if (code7 == CODE_ALT) begin
                            alt_next = !released;
                        end else if (code7 == CODE_CTRL) begin
                            ctrl_next = !released;
                        end else if (!released) begin
                            push_req  = (rom_char != 8'h00);
                            push_data = rom_char;
                        end
                    end
                end
            end
            KIND_WRITE: begin
                push_req = 1'b1;
            end
            KIND_READ: begin
                pop = !ring_empty;
            end
            default: begin
            end
        endcase
    end

    assign push_ok   = push_req && !ring_full;
    assign push_lost = push_req && ring_full;

    // pointer updates
    always_comb begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        if (s_accept && push_ok) begin
            wr_idx_next = wr_inc;
        end
        if (s_accept && pop) begin
            rd_idx_next = rd_inc;
        end
    end

    // control state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_reg    <= 1'b0;
            shift_reg  <= 1'b0;
            ctrl_reg   <= 1'b0;
            alt_reg    <= 1'b0;
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
        end else begin
            if (s_accept) begin
                ext_reg   <= ext_next;
                shift_reg <= shift_next;
                ctrl_reg  <= ctrl_next;
                alt_reg   <= alt_next;
            end
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
        end
    end

    // character ring
    sc2a_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (s_accept && push_ok),
        .wr_addr (wr_idx_reg),
        .wr_data (push_data),
        .rd_en   (s_accept && pop),
        .rd_addr (rd_idx_reg),
        .rd_data (ram_rd_data)
    );

    // middle stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (st1_free) begin
            st1_valid_reg <= s_accept;
        end
    end

    // middle stage payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_pop_reg     <= pop;
            st1_pushed_reg  <= push_ok;
            st1_dropped_reg <= push_lost;
            st1_mods_reg    <= {alt_next, ctrl_next, shift_next};
        end
    end

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= st1_valid_reg;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (out_free && st1_valid_reg) begin
            out_data_reg <= {3'b000, st1_mods_reg, st1_dropped_reg, st1_pushed_reg,
                             st1_pop_reg ? ram_rd_data : 8'h00};
            out_user_reg <= st1_pop_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // a read of an empty ring must not report a character
    a_empty_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && kind_in == KIND_READ && ring_empty) |=> !st1_pop_reg)
        else $error("read of empty ring popped a character");

    // a push into a full ring is reported as dropped and leaves the pointer
    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && kind_in == KIND_WRITE && ring_full)
            |=> (st1_dropped_reg && !st1_pushed_reg && $stable(wr_idx_reg)))
        else $error("write into full ring not dropped");

    // a result word never carries a pop together with a push or a drop
    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser && (m_tdata[8] || m_tdata[9])) && !(m_tdata[8] && m_tdata[9]))
        else $error("conflicting result flags");

    // the read pointer only moves while the ring holds something
    a_rd_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_idx_reg != $past(rd_idx_reg)) |-> ($past(rd_idx_reg) != $past(wr_idx_reg)))
        else $error("read pointer moved on empty ring");

endmodule

>>> hw/rtl/sc2a_ram.sv
// generic single-port-write, single-port-read ram with registered read
module sc2a_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> dv/scancode_to_ascii_fifo_top_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the scancode to ascii translator and its character ring
module scancode_to_ascii_fifo_top_test;
    import sc2a_pkg::*;

    localparam int unsigned RING_DEPTH    = BUFFER_DEPTH_DEF;
    localparam int unsigned RANDOM_WORDS  = 1850;
    localparam int unsigned SEGMENT_WORDS = 300;
    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int unsigned MAX_REPORTS   = 100;
    localparam int unsigned DRAIN_CYCLES  = 8;

    // the one kind value the block has to ignore
    localparam logic [1:0] KIND_IGNORED = 2'd3;
    localparam logic [7:0] BREAK_BIT    = 8'h80;

    // traffic mix per segment of random words
    localparam int unsigned MIX_FILL  = 0;
    localparam int unsigned MIX_DRAIN = 1;
    localparam int unsigned MIX_EVEN  = 2;

    // result word; low six bits are valid, pushed, dropped, shift, ctrl, alt
    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       pushed;
        logic       dropped;
        logic       shift;
        logic       ctrl;
        logic       alt;
    } key_result_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } key_word_t;

    // directed row: input word, whether the result is typed in, typed result
    typedef struct packed {
        key_word_t   word;
        logic        typed;
        key_result_t want;
    } key_row_t;

    localparam key_row_t DIRECTED_ROWS [25] = '{
        {KIND_READ,    8'h00, 1'b1, 8'h00, 6'b000000},  // read of empty ring after reset
        {KIND_IGNORED, 8'hFF, 1'b1, 8'h00, 6'b000000},  // ignored kind
        {KIND_SCAN,    8'h1E, 1'b1, 8'h00, 6'b010000},  // plain 'a' stored
        {KIND_SCAN,    8'h2A, 1'b1, 8'h00, 6'b000100},  // left shift make
        {KIND_SCAN,    8'h1E, 1'b0, 8'h00, 6'b000000},  // shifted 'A'
        {KIND_SCAN,    8'hAA, 1'b1, 8'h00, 6'b000000},  // left shift break
        {KIND_SCAN,    8'h36, 1'b1, 8'h00, 6'b000100},  // right shift make
        {KIND_SCAN,    8'h02, 1'b0, 8'h00, 6'b000000},  // shifted '!'
        {KIND_SCAN,    8'hB6, 1'b1, 8'h00, 6'b000000},  // right shift break
        {KIND_SCAN,    8'h1D, 1'b1, 8'h00, 6'b000010},  // ctrl make
        {KIND_SCAN,    8'h38, 1'b1, 8'h00, 6'b000011},  // alt make
        {KIND_SCAN,    8'hE0, 1'b1, 8'h00, 6'b000011},  // extended prefix
        {KIND_SCAN,    8'h9D, 1'b1, 8'h00, 6'b000011},  // extended ctrl break leaves ctrl
        {KIND_SCAN,    8'hE0, 1'b1, 8'h00, 6'b000011},
        {KIND_SCAN,    8'h1E, 1'b1, 8'h00, 6'b000011},  // extended make gives no char
        {KIND_SCAN,    8'h9D, 1'b1, 8'h00, 6'b000001},  // ctrl break
        {KIND_SCAN,    8'hB8, 1'b1, 8'h00, 6'b000000},  // alt break
        {KIND_SCAN,    8'h5C, 1'b1, 8'h00, 6'b000000},  // first code past the table
        {KIND_SCAN,    8'h7F, 1'b1, 8'h00, 6'b000000},  // highest make code
        {KIND_SCAN,    8'h00, 1'b1, 8'h00, 6'b000000},  // empty table entry
        {KIND_SCAN,    8'h9E, 1'b1, 8'h00, 6'b000000},  // break of an ordinary key
        {KIND_SCAN,    8'h57, 1'b0, 8'h00, 6'b000000},  // table entry above 0x7f
        {KIND_WRITE,   8'h00, 1'b1, 8'h00, 6'b010000},  // zero byte written directly
        {KIND_WRITE,   8'hFF, 1'b1, 8'h00, 6'b010000},
        {KIND_READ,    8'hFF, 1'b0, 8'h00, 6'b000000}   // pops the first stored char
    };

    // translation tables, index is the make code
    localparam logic [7:0] UNSHIFTED_MAP [0:TABLE_LEN-1] = '{
        8'h00,
        8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
        8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74,
        8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61,
        8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B, 8'h27,
        8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D,
        8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h3B, 8'h3C,
        8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h00, 8'h00,
        8'h47, 8'h72, 8'h49, 8'h2D, 8'h4B, 8'h00, 8'h77, 8'h2B, 8'h4F, 8'h80,
        8'h51, 8'h52, 8'h53, 8'h00, 8'h00, 8'h5C, 8'h85, 8'h86, 8'h00, 8'h00,
        8'h00
    };

    localparam logic [7:0] SHIFTED_MAP [0:TABLE_LEN-1] = '{
        8'h00,
        8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28,
        8'h29, 8'h5F, 8'h2B, 8'h08, 8'h15, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54,
        8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'h00, 8'h41,
        8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A, 8'h22,
        8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D,
        8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h54, 8'h55,
        8'h56, 8'h57, 8'h58, 8'h59, 8'h5A, 8'h5B, 8'h5C, 8'h5D, 8'h00, 8'h00,
        8'h47, 8'h72, 8'h49, 8'h2D, 8'h4B, 8'h00, 8'h77, 8'h2B, 8'h4F, 8'h80,
        8'h51, 8'h52, 8'h53, 8'h00, 8'h00, 8'h5C, 8'h87, 8'h88, 8'h00, 8'h00,
        8'h00
    };

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = 8'h00;   // data_byte[7:0]
    logic [1:0]            s_tuser  = 2'b00;   // kind[1:0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // char_out[7:0], pushed, dropped, shift_held, ctrl_held, alt_held, zero[15:13]
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;           // char_valid

    // translator state mirrored by the predictor
    logic        ext_armed = 1'b0;
    logic        shift_on  = 1'b0;
    logic        ctrl_on   = 1'b0;
    logic        alt_on    = 1'b0;
    logic [7:0]  ring [RING_DEPTH];
    int unsigned rd_slot   = 0;
    int unsigned wr_slot   = 0;

    key_result_t due_results [$];
    key_word_t   pending_words [$];
    int unsigned failures     = 0;
    int unsigned send_gap_pct = 10;
    int unsigned stall_pct    = 48;
    int unsigned quiet_cycles = 0;

    scancode_to_ascii_fifo_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    // ring push, returns 1 when the char found room
    function automatic logic store_char(input logic [7:0] c);
        int unsigned nxt;
        nxt = (wr_slot + 1) % RING_DEPTH;
        if (nxt == rd_slot) return 1'b0;
        ring[wr_slot] = c;
        wr_slot = nxt;
        return 1'b1;
    endfunction

    // expected result of one accepted word, advances the mirrored state
    function automatic key_result_t translate_word(input key_word_t w);
        key_result_t r;
        logic        brk;
        logic [7:0]  code;
        logic [7:0]  c;
        r = '0;
        case (w.kind)
            KIND_SCAN: begin
                if (w.data == CODE_EXT_PREFIX) begin
                    ext_armed = 1'b1;
                end else begin
                    brk = w.data[7];
                    code = {ext_armed, w.data[6:0]};
                    ext_armed = 1'b0;
                    if (code == {1'b0, CODE_LSHIFT} || code == {1'b0, CODE_RSHIFT}) begin
                        shift_on = !brk;
                    end else if (code == {1'b0, CODE_ALT}) begin
                        alt_on = !brk;
                    end else if (code == {1'b0, CODE_CTRL}) begin
                        ctrl_on = !brk;
                    end else if (!brk && code < TABLE_LEN) begin
                        c = shift_on ? SHIFTED_MAP[code] : UNSHIFTED_MAP[code];
                        if (c != 8'h00) begin
                            if (store_char(c)) r.pushed = 1'b1;
                            else r.dropped = 1'b1;
                        end
                    end
                end
            end
            KIND_WRITE: begin
                if (store_char(w.data)) r.pushed = 1'b1;
                else r.dropped = 1'b1;
            end
            KIND_READ: begin
                if (rd_slot != wr_slot) begin
                    r.ch = ring[rd_slot];
                    r.valid = 1'b1;
                    rd_slot = (rd_slot + 1) % RING_DEPTH;
                end
            end
            default: ;
        endcase
        r.shift = shift_on;
        r.ctrl = ctrl_on;
        r.alt = alt_on;
        return r;
    endfunction

    // random traffic: whole keystrokes, direct writes, reads and noise, in a mix set per segment
    task automatic queue_random_batch(input int unsigned mix);
        int unsigned read_pct;
        int unsigned write_pct;
        int unsigned pick;
        logic [6:0]  key;
        logic [6:0]  modifier;
        logic        use_mod;
        logic        extended;
        case (mix)
            MIX_FILL:  begin read_pct = 2;  write_pct = 60; end
            MIX_DRAIN: begin read_pct = 60; write_pct = 10; end
            default:   begin read_pct = 25; write_pct = 25; end
        endcase
        pick = $urandom_range(99);
        if (pick < read_pct) begin
            pending_words.push_back({KIND_READ, 8'($urandom_range(255))});
        end else if (pick < read_pct + write_pct) begin
            pending_words.push_back({KIND_WRITE, 8'($urandom_range(255))});
        end else if (pick < read_pct + write_pct + 5) begin
            pending_words.push_back({2'($urandom_range(3)), 8'($urandom_range(255))});
        end else begin
            key = ($urandom_range(9) == 0) ? 7'($urandom_range(TABLE_LEN, 127))
                                           : 7'($urandom_range(1, TABLE_LEN - 1));
            case ($urandom_range(3))
                0:       modifier = CODE_LSHIFT;
                1:       modifier = CODE_RSHIFT;
                2:       modifier = CODE_CTRL;
                default: modifier = CODE_ALT;
            endcase
            use_mod = ($urandom_range(99) < 40);
            extended = ($urandom_range(99) < 10);
            if (use_mod) pending_words.push_back({KIND_SCAN, 1'b0, modifier});
            if (extended) pending_words.push_back({KIND_SCAN, CODE_EXT_PREFIX});
            pending_words.push_back({KIND_SCAN, 1'b0, key});
            if (extended) pending_words.push_back({KIND_SCAN, CODE_EXT_PREFIX});
            pending_words.push_back({KIND_SCAN, BREAK_BIT | {1'b0, key}});
            // now and then the modifier release goes missing
            if (use_mod && $urandom_range(9) != 0)
                pending_words.push_back({KIND_SCAN, BREAK_BIT | {1'b0, modifier}});
        end
    endtask

    // offer one word on the input channel, return at the edge that takes it
    task automatic send_word(input key_word_t w);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= w.kind;
        s_tdata <= w.data;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
    endtask

    // result side back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // compare each taken result word with the oldest expectation
    always @(negedge aclk) begin : check_results
        key_result_t got;
        key_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[7:0], m_tuser, m_tdata[8], m_tdata[9], m_tdata[10], m_tdata[11],
                   m_tdata[12]};
            if (due_results.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: unexpected result word, expected none, got tdata %h tuser %b",
                             $time, m_tdata, m_tuser);
            end else begin
                want = due_results.pop_front();
                if (got !== want || m_tdata[15:13] !== 3'b000) begin
                    failures++;
                    // flags are valid, pushed, dropped, shift, ctrl, alt
                    if (failures <= MAX_REPORTS)
                        $display("%0t: expected char %h flags %b, got char %h flags %b, pad %b",
                                 $time, want.ch, want[5:0], got.ch, got[5:0],
                                 m_tdata[15:13]);
                end
            end
        end
    end

    // watchdog on cycles where neither channel moves a word
    always @(negedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // reset, directed table, random traffic, drain
    initial begin : stimulus
        int unsigned sent;
        key_word_t   w;
        key_result_t r;
        sent = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED_ROWS[i]) begin
            send_word(DIRECTED_ROWS[i].word);
            r = translate_word(DIRECTED_ROWS[i].word);
            due_results.push_back(DIRECTED_ROWS[i].typed ? DIRECTED_ROWS[i].want : r);
        end

        while (sent < RANDOM_WORDS || pending_words.size() != 0) begin
            // idle pattern by thirds of the random run
            case ((sent * 3) / RANDOM_WORDS)
                0:       begin send_gap_pct = 10; stall_pct = 48; end
                1:       begin send_gap_pct = 48; stall_pct = 10; end
                default: begin send_gap_pct = 0;  stall_pct = 0;  end
            endcase
            if (pending_words.size() == 0)
                queue_random_batch((sent / SEGMENT_WORDS) % 3);
            w = pending_words.pop_front();
            send_word(w);
            due_results.push_back(translate_word(w));
            sent++;
        end
        s_tvalid <= 1'b0;

        while (due_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
